// File: src/psc_pkg.sv
// Shared types and constants for the PSI section stream classifier.
package psc_pkg;

  // Table ids handled
  localparam logic [7:0] TID_PAT = 8'h00;
  localparam logic [7:0] TID_PMT = 8'h02;

  // Elementary stream types
  localparam logic [7:0] ST_MPEG2_VIDEO = 8'h02;
  localparam logic [7:0] ST_H264_VIDEO  = 8'h1b;
  localparam logic [7:0] ST_MPEG1_AUDIO = 8'h03;
  localparam logic [7:0] ST_MPEG2_AUDIO = 8'h04;
  localparam logic [7:0] ST_LATM_AUDIO  = 8'h11;
  localparam logic [7:0] ST_PRIVATE_PES = 8'h06;

  // Descriptor tags of interest
  localparam logic [7:0] TAG_AC3      = 8'h6a;
  localparam logic [7:0] TAG_EAC3     = 8'h7a;
  localparam logic [7:0] TAG_SUBTITLE = 8'h59;
  localparam logic [7:0] TAG_TELETEXT = 8'h56;

  // Bits of the tags-seen mask
  localparam int unsigned TS_AC3      = 0;
  localparam int unsigned TS_EAC3     = 1;
  localparam int unsigned TS_SUBTITLE = 2;
  localparam int unsigned TS_TELETEXT = 3;

  // Header byte offsets
  localparam logic [11:0] POS_TABLE_ID   = 12'd0;
  localparam logic [11:0] POS_LEN_HI     = 12'd1;
  localparam logic [11:0] POS_LEN_LO     = 12'd2;
  localparam logic [11:0] POS_EXT_HI     = 12'd3;
  localparam logic [11:0] POS_EXT_LO     = 12'd4;
  localparam logic [11:0] POS_PCR_HI     = 12'd8;
  localparam logic [11:0] POS_PCR_LO     = 12'd9;
  localparam logic [11:0] POS_PINFO_HI   = 12'd10;
  localparam logic [11:0] POS_PINFO_LO   = 12'd11;
  localparam logic [11:0] POS_PAT_LOOP   = 12'd8;
  localparam logic [11:0] POS_PMT_LOOP   = 12'd12;
  localparam logic [11:0] POS_MIN_LEN    = 12'd4;
  localparam logic [11:0] POS_MAX        = 12'hfff;

  // Entry kinds carried on the result channel
  typedef enum logic [3:0] {
    KIND_PROGRAM  = 4'd0,
    KIND_MAP_PID  = 4'd1,
    KIND_PCR      = 4'd2,
    KIND_VIDEO    = 4'd3,
    KIND_AUDIO    = 4'd4,
    KIND_AC3      = 4'd5,
    KIND_TELETEXT = 4'd6,
    KIND_PRIVATE  = 4'd7,
    KIND_END      = 4'd8
  } entry_kind_e;

  // End-of-section status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_SHORT     = 2'd1,
    STAT_IGNORED   = 2'd2,
    STAT_TRUNCATED = 2'd3
  } end_status_e;

  // Parser state for one section
  typedef struct packed {
    logic [11:0] byte_pos;
    logic [7:0]  table_kind;
    logic        long_syntax;
    logic [11:0] sec_len;
    logic [15:0] prog_num;
    logic [15:0] field_hold;
    logic [11:0] info_skip;
    logic [2:0]  phase;
    logic [7:0]  stream_type;
    logic [12:0] entry_pid;
    logic [11:0] info_left;
    logic [7:0]  desc_left;
    logic [3:0]  tags_seen;
    logic        walk_stopped;
    logic [12:0] map_pid;
  } sec_state_t;

  // One result item
  typedef struct packed {
    entry_kind_e kind;
    logic [12:0] pid;
    logic [15:0] prog;
    end_status_e status;
  } result_t;

endpackage

// File: src/psi_section_stream_classifier.sv
// PSI section parser: PAT/PMT bytes in, program and stream entries out.
// A result is registered and valid in the cycle after the transfer of the byte that causes it.
// The parser takes one section byte per cycle while the result channel does not stall it; the parser state updates
// once per byte in a single stage and the result register drains while the next byte is taken.
// Reset: asynchronous, active low; clears the parser state, leaves the parser
// outside any section and empties the result register.
module psi_section_stream_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // data_byte[7:0], source_pid[20:8], zero pad
  input  logic        s_axis_tuser_i,   // start_of_section
  input  logic        s_axis_tlast_i,   // end_of_data
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // stream_pid[12:0], program_number[28:13],
                                        // end_status[30:29], zero pad
  output logic [3:0]  m_axis_tuser_o    // entry_kind
);
  import psc_pkg::*;

  sec_state_t  st_q, st_d, cur;
  logic        in_sec_q, in_sec_d, cur_in;
  result_t     res_q, res_d;
  logic        m_valid_q;
  logic        s_xfer;
  logic        emit, done_es, walk;
  logic        pat, pmt, pat_end, pmt_end;
  logic [7:0]  b;
  logic [11:0] pos, loop_end, loop_end_fin;
  entry_kind_e kind_v;
  logic [12:0] pid_v;
  logic [15:0] prog_v;

  assign b      = s_axis_tdata_i[7:0];
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // Elementary stream classification; hit is low when the stream gives no entry
  function automatic logic classify_hit(input logic [7:0] t, input logic [12:0] p);
    logic hit;
    hit = 1'b0;
    if (t == ST_MPEG1_AUDIO || t == ST_MPEG2_AUDIO || t == ST_LATM_AUDIO ||
        t == ST_MPEG2_VIDEO || t == ST_H264_VIDEO) begin
      hit = (p != 13'd0);
    end else if (t == ST_PRIVATE_PES) begin
      hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic entry_kind_e classify_kind(input logic [7:0] t, input logic [3:0] tags);
    entry_kind_e k;
    k = KIND_PRIVATE;
    if (t == ST_MPEG1_AUDIO || t == ST_MPEG2_AUDIO || t == ST_LATM_AUDIO) begin
      k = KIND_AUDIO;
    end else if (t == ST_MPEG2_VIDEO || t == ST_H264_VIDEO) begin
      k = KIND_VIDEO;
    end else if (tags[TS_AC3] || tags[TS_EAC3]) begin
      k = KIND_AC3;
    end else if (tags[TS_SUBTITLE] || tags[TS_TELETEXT]) begin
      k = KIND_TELETEXT;
    end
    return k;
  endfunction

  // Per-byte parser step
  always_comb begin
    cur    = st_q;
    cur_in = in_sec_q;
    if (s_axis_tuser_i) begin
      cur         = '0;
      cur.map_pid = s_axis_tdata_i[20:8];
      cur_in      = 1'b1;
    end
    st_d     = cur;
    in_sec_d = cur_in;
    emit     = 1'b0;
    done_es  = 1'b0;
    walk     = 1'b0;
    kind_v   = KIND_PROGRAM;
    pid_v    = '0;
    prog_v   = '0;
    res_d    = '0;

    pos      = cur.byte_pos;
    loop_end = (cur.sec_len != 12'd0) ? cur.sec_len - 12'd1 : 12'd0;
    pat      = cur.long_syntax && (cur.table_kind == TID_PAT);
    pmt      = cur.long_syntax && (cur.table_kind == TID_PMT);

    if (cur_in) begin
      if (cur.byte_pos != POS_MAX) st_d.byte_pos = cur.byte_pos + 12'd1;

      priority if (pos == POS_TABLE_ID) begin
        st_d.table_kind = b;
      end else if (pos == POS_LEN_HI) begin
        st_d.long_syntax = b[7];
        st_d.sec_len     = {b[3:0], 8'h00};
      end else if (pos == POS_LEN_LO) begin
        st_d.sec_len = cur.sec_len | {4'h0, b};
      end else if (pat || pmt) begin
        priority if (pos == POS_EXT_HI) begin
          st_d.field_hold = {b, 8'h00};
        end else if (pos == POS_EXT_LO) begin
          st_d.prog_num = cur.field_hold | {8'h00, b};
          if (pmt && cur.map_pid != 13'd0) begin
            emit   = 1'b1;
            kind_v = KIND_MAP_PID;
            pid_v  = cur.map_pid;
            prog_v = st_d.prog_num;
          end
        end else if (pmt && (pos == POS_PCR_HI || pos == POS_PINFO_HI)) begin
          st_d.field_hold = {b, 8'h00};
        end else if (pmt && pos == POS_PCR_LO) begin
          pid_v = cur.field_hold[12:0] | {5'h00, b};
          if (pid_v != 13'd0) begin
            emit   = 1'b1;
            kind_v = KIND_PCR;
            prog_v = cur.prog_num;
          end
        end else if (pmt && pos == POS_PINFO_LO) begin
          st_d.info_skip = cur.field_hold[11:0] | {4'h0, b};
        end else if (pat && pos >= POS_PAT_LOOP && pos < loop_end) begin
          // PAT loop: program number, reserved bits + PID
          unique case (cur.phase)
            3'd0: begin
              st_d.field_hold = {b, 8'h00};
              st_d.phase      = 3'd1;
            end
            3'd1: begin
              st_d.field_hold = cur.field_hold | {8'h00, b};
              st_d.phase      = 3'd2;
            end
            3'd2: begin
              st_d.stream_type = b;
              st_d.entry_pid   = {b[4:0], 8'h00};
              st_d.phase       = 3'd3;
            end
            default: begin
              st_d.entry_pid = cur.entry_pid | {5'h00, b};
              st_d.phase     = 3'd0;
              pid_v          = st_d.entry_pid;
              prog_v         = cur.field_hold;
              if (cur.field_hold != 16'd0 && cur.stream_type[7:5] == 3'b111) begin
                emit   = 1'b1;
                kind_v = KIND_PROGRAM;
              end
            end
          endcase
        end else if (pmt && pos >= POS_PMT_LOOP && pos < loop_end) begin
          if (cur.info_skip != 12'd0) begin
            st_d.info_skip = cur.info_skip - 12'd1;
          end else begin
            // PMT elementary stream loop
            unique case (cur.phase)
              3'd0: begin
                st_d.stream_type  = b;
                st_d.tags_seen    = '0;
                st_d.walk_stopped = 1'b0;
                st_d.phase        = 3'd1;
              end
              3'd1: begin
                st_d.entry_pid = {b[4:0], 8'h00};
                st_d.phase     = 3'd2;
              end
              3'd2: begin
                st_d.entry_pid = cur.entry_pid | {5'h00, b};
                st_d.phase     = 3'd3;
              end
              3'd3: begin
                st_d.field_hold = {4'h0, b[3:0], 8'h00};
                st_d.phase      = 3'd4;
              end
              3'd4: begin
                st_d.info_left = cur.field_hold[11:0] | {4'h0, b};
                if (st_d.info_left == 12'd0) begin
                  st_d.phase = 3'd0;
                  done_es    = 1'b1;
                end else begin
                  st_d.phase = 3'd5;
                end
              end
              default: walk = 1'b1;
            endcase

            // Descriptor walk inside the ES info
            if (walk) begin
              if (!cur.walk_stopped) begin
                if (cur.phase == 3'd5) begin
                  st_d.field_hold = {8'h00, b};
                  st_d.phase      = 3'd6;
                end else if (cur.phase == 3'd6) begin
                  if (b == 8'h00) begin
                    st_d.walk_stopped = 1'b1;
                  end else begin
                    if (cur.field_hold == {8'h00, TAG_AC3})      st_d.tags_seen[TS_AC3] = 1'b1;
                    if (cur.field_hold == {8'h00, TAG_EAC3})     st_d.tags_seen[TS_EAC3] = 1'b1;
                    if (cur.field_hold == {8'h00, TAG_SUBTITLE}) begin
                      st_d.tags_seen[TS_SUBTITLE] = 1'b1;
                    end
                    if (cur.field_hold == {8'h00, TAG_TELETEXT}) begin
                      st_d.tags_seen[TS_TELETEXT] = 1'b1;
                    end
                    st_d.desc_left = b;
                    st_d.phase     = 3'd7;
                  end
                end else begin
                  st_d.desc_left = cur.desc_left - 8'd1;
                  if (cur.desc_left == 8'd1) st_d.phase = 3'd5;
                end
              end
              st_d.info_left = cur.info_left - 12'd1;
              if (cur.info_left == 12'd1) begin
                st_d.phase = 3'd0;
                done_es    = 1'b1;
              end
            end

            pid_v  = st_d.entry_pid;
            prog_v = cur.prog_num;
            if (done_es) begin
              emit   = classify_hit(st_d.stream_type, st_d.entry_pid);
              kind_v = classify_kind(st_d.stream_type, st_d.tags_seen);
            end
          end
        end else begin
          // reserved header bytes, CRC and trailing bytes carry nothing
        end
      end else begin
        // unhandled table: only the header is tracked
      end

      // Result selection: end of section overrides any entry
      if (s_axis_tlast_i) begin
        pat_end      = st_d.long_syntax && (st_d.table_kind == TID_PAT);
        pmt_end      = st_d.long_syntax && (st_d.table_kind == TID_PMT);
        loop_end_fin = (st_d.sec_len != 12'd0) ? st_d.sec_len - 12'd1 : 12'd0;
        in_sec_d     = 1'b0;
        res_d.kind   = KIND_END;
        priority if (st_d.byte_pos < POS_MIN_LEN) begin
          res_d.status = STAT_SHORT;
        end else if (!pat_end && !pmt_end) begin
          res_d.status = STAT_IGNORED;
        end else if (emit || st_d.byte_pos < loop_end_fin || st_d.phase != 3'd0 ||
                     (pmt_end && st_d.info_skip != 12'd0)) begin
          res_d.status = STAT_TRUNCATED;
        end else begin
          res_d.status = STAT_OK;
        end
      end else begin
        pat_end      = 1'b0;
        pmt_end      = 1'b0;
        loop_end_fin = '0;
        res_d.kind   = kind_v;
        res_d.pid    = pid_v;
        res_d.prog   = prog_v;
        res_d.status = STAT_OK;
      end
    end else begin
      pat_end      = 1'b0;
      pmt_end      = 1'b0;
      loop_end_fin = '0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= '0;
      in_sec_q <= 1'b0;
    end else if (s_xfer) begin
      st_q     <= st_d;
      in_sec_q <= in_sec_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_xfer && cur_in && (emit || s_axis_tlast_i)) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer && cur_in && (emit || s_axis_tlast_i)) begin
      res_q <= res_d;
    end
  end

  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = res_q.kind;
  assign m_axis_tdata_o  = {1'b0, res_q.status, res_q.prog, res_q.pid};

  // End results carry no PID and no program
  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_q.kind == KIND_END) |-> (res_q.pid == 13'd0 && res_q.prog == 16'd0))
    else $error("end result with nonzero pid or program");

  // Entry results carry zero status
  a_entry_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_q.kind != KIND_END) |-> (res_q.status == STAT_OK))
    else $error("entry result with nonzero status");

  // A byte outside any section leaves the parser state alone
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && !s_axis_tuser_i && !in_sec_q) |=> ($stable(st_q) && !in_sec_q))
    else $error("state moved outside a section");

  // The last byte closes the section
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && s_axis_tlast_i) |=> !in_sec_q)
    else $error("section still open after last byte");

  // A start byte that is not also the last byte opens a section and restarts the byte count
  a_start_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && s_axis_tuser_i && !s_axis_tlast_i) |=> (in_sec_q && st_q.byte_pos == 12'd1))
    else $error("start byte did not open a section");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the PSI section classifier: section byte stream in, entries checked out.
module tb_top;
  import psc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned HOLD_AT     = 200;   // accepted bytes before the long output hold
  localparam int unsigned HOLD_LEN    = 300;   // start value of that hold's countdown
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam logic [7:0]  TID_OTHER   = 8'h42;
  localparam logic [7:0]  TAG_CA      = 8'h0a;
  localparam logic [7:0]  TAG_STREAM  = 8'h52;

  // One section byte as the sender presents it
  typedef struct packed {
    logic        sos;
    logic [7:0]  b;
    logic        eod;
    logic [12:0] pid;
  } byte_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [3:0]  m_tuser;

  psi_section_stream_classifier dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state and bookkeeping
  sec_state_t  sec;
  bit          in_section;
  result_t     expected_entries[$];
  byte_item_t  pending_bytes[$];
  logic [7:0]  sec_q[$];
  logic [7:0]  body_q[$];
  logic [7:0]  desc_q[$];
  int unsigned gen_count;
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned in_count;
  bit          in_taken;
  bit          hold_on, hold_done;
  int unsigned hold_left;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Kind of an elementary stream once its ES info is done
  function automatic bit classify_stream(output entry_kind_e k);
    logic [7:0] t;
    t = sec.stream_type;
    k = KIND_PRIVATE;
    if (t == ST_MPEG1_AUDIO || t == ST_MPEG2_AUDIO || t == ST_LATM_AUDIO) begin
      k = KIND_AUDIO;
      return sec.entry_pid != '0;
    end
    if (t == ST_MPEG2_VIDEO || t == ST_H264_VIDEO) begin
      k = KIND_VIDEO;
      return sec.entry_pid != '0;
    end
    if (t == ST_PRIVATE_PES) begin
      if (sec.tags_seen[TS_AC3] || sec.tags_seen[TS_EAC3]) k = KIND_AC3;
      else if (sec.tags_seen[TS_SUBTITLE] || sec.tags_seen[TS_TELETEXT]) k = KIND_TELETEXT;
      else k = KIND_PRIVATE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // One byte of the PAT program loop
  function automatic bit pat_loop_byte(input logic [7:0] b, output entry_kind_e k);
    k = KIND_PROGRAM;
    case (sec.phase)
      3'd0: begin
        sec.field_hold = {b, 8'h00};
        sec.phase = 3'd1;
        return 1'b0;
      end
      3'd1: begin
        sec.field_hold = sec.field_hold | {8'h00, b};
        sec.phase = 3'd2;
        return 1'b0;
      end
      3'd2: begin
        sec.stream_type = b;
        sec.entry_pid = {b[4:0], 8'h00};
        sec.phase = 3'd3;
        return 1'b0;
      end
      default: begin
        sec.entry_pid = sec.entry_pid | {5'h00, b};
        sec.phase = 3'd0;
        return sec.field_hold != '0 && sec.stream_type[7:5] == 3'b111;
      end
    endcase
  endfunction

  // One byte of the PMT elementary stream loop, descriptor walk included
  function automatic bit es_loop_byte(input logic [7:0] b, output entry_kind_e k);
    k = KIND_PRIVATE;
    case (sec.phase)
      3'd0: begin
        sec.stream_type = b;
        sec.tags_seen = '0;
        sec.walk_stopped = 1'b0;
        sec.phase = 3'd1;
        return 1'b0;
      end
      3'd1: begin
        sec.entry_pid = {b[4:0], 8'h00};
        sec.phase = 3'd2;
        return 1'b0;
      end
      3'd2: begin
        sec.entry_pid = sec.entry_pid | {5'h00, b};
        sec.phase = 3'd3;
        return 1'b0;
      end
      3'd3: begin
        sec.field_hold = {4'h0, b[3:0], 8'h00};
        sec.phase = 3'd4;
        return 1'b0;
      end
      3'd4: begin
        sec.info_left = sec.field_hold[11:0] | {4'h0, b};
        if (sec.info_left == '0) begin
          sec.phase = 3'd0;
          return classify_stream(k);
        end
        sec.phase = 3'd5;
        return 1'b0;
      end
      default: ;
    endcase
    if (!sec.walk_stopped) begin
      if (sec.phase == 3'd5) begin
        sec.field_hold = {8'h00, b};
        sec.phase = 3'd6;
      end else if (sec.phase == 3'd6) begin
        if (b == 8'h00) begin
          sec.walk_stopped = 1'b1;
        end else begin
          if (sec.field_hold[7:0] == TAG_AC3)      sec.tags_seen[TS_AC3] = 1'b1;
          if (sec.field_hold[7:0] == TAG_EAC3)     sec.tags_seen[TS_EAC3] = 1'b1;
          if (sec.field_hold[7:0] == TAG_SUBTITLE) sec.tags_seen[TS_SUBTITLE] = 1'b1;
          if (sec.field_hold[7:0] == TAG_TELETEXT) sec.tags_seen[TS_TELETEXT] = 1'b1;
          sec.desc_left = b;
          sec.phase = 3'd7;
        end
      end else begin
        sec.desc_left = sec.desc_left - 8'd1;
        if (sec.desc_left == '0) sec.phase = 3'd5;
      end
    end
    sec.info_left = sec.info_left - 12'd1;
    if (sec.info_left == '0) begin
      sec.phase = 3'd0;
      return classify_stream(k);
    end
    return 1'b0;
  endfunction

  // Full per-byte prediction; returns 1 when the byte causes a result
  function automatic bit parse_section_byte(input byte_item_t it, output result_t res);
    logic [11:0] pos, loop_end, n;
    bit          is_pat, is_pmt, hit;
    entry_kind_e k;
    logic [12:0] pid;
    logic [15:0] prog;
    end_status_e st;
    hit = 1'b0;
    k = KIND_PROGRAM;
    pid = '0;
    prog = '0;
    res = '0;
    if (it.sos) begin
      sec = '0;
      in_section = 1'b1;
      sec.map_pid = it.pid;
    end
    if (!in_section) return 1'b0;

    pos = sec.byte_pos;
    if (sec.byte_pos != POS_MAX) sec.byte_pos = sec.byte_pos + 12'd1;
    loop_end = (sec.sec_len >= 12'd1) ? sec.sec_len - 12'd1 : 12'd0;
    is_pat = sec.long_syntax && sec.table_kind == TID_PAT;
    is_pmt = sec.long_syntax && sec.table_kind == TID_PMT;

    if (pos == POS_TABLE_ID) begin
      sec.table_kind = it.b;
    end else if (pos == POS_LEN_HI) begin
      sec.long_syntax = it.b[7];
      sec.sec_len = {it.b[3:0], 8'h00};
    end else if (pos == POS_LEN_LO) begin
      sec.sec_len = sec.sec_len | {4'h0, it.b};
    end else if (is_pat || is_pmt) begin
      if (pos == POS_EXT_HI) begin
        sec.field_hold = {it.b, 8'h00};
      end else if (pos == POS_EXT_LO) begin
        sec.prog_num = sec.field_hold | {8'h00, it.b};
        if (is_pmt && sec.map_pid != '0) begin
          hit = 1'b1;
          k = KIND_MAP_PID;
          pid = sec.map_pid;
          prog = sec.prog_num;
        end
      end else if (is_pmt && (pos == POS_PCR_HI || pos == POS_PINFO_HI)) begin
        sec.field_hold = {it.b, 8'h00};
      end else if (is_pmt && pos == POS_PCR_LO) begin
        pid = sec.field_hold[12:0] | {5'h00, it.b};
        if (pid != '0) begin
          hit = 1'b1;
          k = KIND_PCR;
          prog = sec.prog_num;
        end
      end else if (is_pmt && pos == POS_PINFO_LO) begin
        sec.info_skip = sec.field_hold[11:0] | {4'h0, it.b};
      end else if (is_pat && pos >= POS_PAT_LOOP && pos < loop_end) begin
        hit = pat_loop_byte(it.b, k);
        pid = sec.entry_pid;
        prog = sec.field_hold;
      end else if (is_pmt && pos >= POS_PMT_LOOP && pos < loop_end) begin
        if (sec.info_skip != '0) begin
          sec.info_skip = sec.info_skip - 12'd1;
        end else begin
          hit = es_loop_byte(it.b, k);
          pid = sec.entry_pid;
          prog = sec.prog_num;
        end
      end
    end

    // End of data always closes the section with a status
    if (it.eod) begin
      is_pat = sec.long_syntax && sec.table_kind == TID_PAT;
      is_pmt = sec.long_syntax && sec.table_kind == TID_PMT;
      loop_end = (sec.sec_len >= 12'd1) ? sec.sec_len - 12'd1 : 12'd0;
      n = sec.byte_pos;
      if (n < POS_MIN_LEN) st = STAT_SHORT;
      else if (!is_pat && !is_pmt) st = STAT_IGNORED;
      else if (hit || n < loop_end || sec.phase != '0 || (is_pmt && sec.info_skip != '0))
        st = STAT_TRUNCATED;
      else st = STAT_OK;
      in_section = 1'b0;
      res.kind = KIND_END;
      res.pid = '0;
      res.prog = '0;
      res.status = st;
      return 1'b1;
    end
    if (!hit) return 1'b0;
    res.kind = k;
    res.pid = pid;
    res.prog = prog;
    res.status = STAT_OK;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [12:0] rand_pid();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 13'h0000;
    if (r == 1) return 13'h1fff;
    return 13'($urandom);
  endfunction

  function automatic logic [7:0] rand_tag();
    case ($urandom_range(0, 6))
      0: return TAG_AC3;
      1: return TAG_EAC3;
      2: return TAG_SUBTITLE;
      3: return TAG_TELETEXT;
      4: return TAG_CA;
      5: return TAG_STREAM;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_stream_type();
    case ($urandom_range(0, 8))
      0: return ST_MPEG2_VIDEO;
      1: return ST_H264_VIDEO;
      2: return ST_MPEG1_AUDIO;
      3: return ST_MPEG2_AUDIO;
      4: return ST_LATM_AUDIO;
      5, 6, 7: return ST_PRIVATE_PES;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_byte(input bit sos, input logic [7:0] b, input bit eod,
                          input logic [12:0] pid, input bit counts);
    byte_item_t it;
    it.sos = sos;
    it.b = b;
    it.eod = eod;
    it.pid = pid;
    pending_bytes.insert(pending_bytes.size(), it);
    if (counts) gen_count++;
  endtask

  task automatic build_pat();
    int unsigned nprog;
    logic [11:0] slen;
    logic [15:0] pn;
    logic [12:0] pp;
    logic [7:0]  rsv;
    nprog = $urandom_range(0, 4);
    slen = 12'(9 + 4 * nprog);
    rsv = 8'($urandom);
    sec_q.delete();
    sec_q.insert(sec_q.size(), TID_PAT);
    sec_q.insert(sec_q.size(), {1'b1, rsv[6:4], slen[11:8]});
    sec_q.insert(sec_q.size(), slen[7:0]);
    repeat (5) sec_q.insert(sec_q.size(), 8'($urandom));
    repeat (nprog) begin
      case ($urandom_range(0, 7))
        0: pn = 16'h0000;
        1: pn = 16'hffff;
        default: pn = 16'($urandom);
      endcase
      rsv = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'hff;
      pp = rand_pid();
      sec_q.insert(sec_q.size(), pn[15:8]);
      sec_q.insert(sec_q.size(), pn[7:0]);
      sec_q.insert(sec_q.size(), {rsv[7:5], pp[12:8]});
      sec_q.insert(sec_q.size(), pp[7:0]);
    end
    repeat (4) sec_q.insert(sec_q.size(), 8'($urandom));
  endtask

  // ES info: descriptors of random tags, some zero length, sometimes a lone tag at the end
  task automatic build_descriptors();
    int unsigned nd, dl;
    desc_q.delete();
    nd = $urandom_range(0, 3);
    repeat (nd) begin
      dl = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      desc_q.insert(desc_q.size(), rand_tag());
      desc_q.insert(desc_q.size(), 8'(dl));
      repeat (dl) desc_q.insert(desc_q.size(), 8'($urandom));
    end
    if ($urandom_range(0, 6) == 0) desc_q.insert(desc_q.size(), rand_tag());
  endtask

  task automatic build_pmt();
    int unsigned pil, nes;
    logic [11:0] slen, il;
    logic [15:0] pn;
    logic [12:0] pcr, epid;
    logic [7:0]  rsv;
    body_q.delete();
    pil = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    repeat (pil) body_q.insert(body_q.size(), 8'($urandom));
    nes = $urandom_range(0, 4);
    repeat (nes) begin
      epid = rand_pid();
      rsv = 8'($urandom);
      build_descriptors();
      il = 12'(desc_q.size());
      body_q.insert(body_q.size(), rand_stream_type());
      body_q.insert(body_q.size(), {rsv[7:5], epid[12:8]});
      body_q.insert(body_q.size(), epid[7:0]);
      body_q.insert(body_q.size(), {rsv[3:0], il[11:8]});
      body_q.insert(body_q.size(), il[7:0]);
      foreach (desc_q[i]) body_q.insert(body_q.size(), desc_q[i]);
    end
    slen = 12'(9 + body_q.size() + 4);
    pn = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom);
    pcr = rand_pid();
    rsv = 8'($urandom);
    sec_q.delete();
    sec_q.insert(sec_q.size(), TID_PMT);
    sec_q.insert(sec_q.size(), {1'b1, rsv[6:4], slen[11:8]});
    sec_q.insert(sec_q.size(), slen[7:0]);
    sec_q.insert(sec_q.size(), pn[15:8]);
    sec_q.insert(sec_q.size(), pn[7:0]);
    repeat (3) sec_q.insert(sec_q.size(), 8'($urandom));
    rsv = 8'($urandom);
    sec_q.insert(sec_q.size(), {rsv[7:5], pcr[12:8]});
    sec_q.insert(sec_q.size(), pcr[7:0]);
    sec_q.insert(sec_q.size(), {rsv[3:0], 4'(pil >> 8)});
    sec_q.insert(sec_q.size(), 8'(pil));
    foreach (body_q[i]) sec_q.insert(sec_q.size(), body_q[i]);
    repeat (4) sec_q.insert(sec_q.size(), 8'($urandom));
  endtask

  task automatic build_other();
    int unsigned len;
    len = $urandom_range(4, 12);
    sec_q.delete();
    sec_q.insert(sec_q.size(), ($urandom_range(0, 1) == 0) ? TID_OTHER : 8'($urandom));
    repeat (len - 1) sec_q.insert(sec_q.size(), 8'($urandom));
  endtask

  // Push sec_q as one section, possibly damaged, cut, unterminated, overrun or followed by stray bytes
  task automatic send_section();
    int unsigned r, last, extra;
    logic [12:0] pid;
    logic [7:0]  tmp;
    pid = rand_pid();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      tmp = sec_q[1];
      tmp[3:0] = 4'($urandom);
      sec_q[1] = tmp;
      sec_q[2] = 8'($urandom);
    end else if (r < 12) begin
      tmp = sec_q[1];
      tmp[7] = 1'b0;
      sec_q[1] = tmp;
    end else if (r < 16) begin
      sec_q[0] = 8'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 74) begin
      last = sec_q.size() - 1;
      for (int i = 0; i <= last; i++)
        add_byte(i == 0, sec_q[i], i == last, (i == 0) ? pid : 13'($urandom), 1'b1);
    end else if (r < 82) begin
      last = $urandom_range(0, sec_q.size() - 1);
      for (int i = 0; i <= last; i++)
        add_byte(i == 0, sec_q[i], i == last, (i == 0) ? pid : 13'($urandom), 1'b1);
    end else if (r < 88) begin
      // next start byte lands inside this section
      for (int i = 0; i < sec_q.size(); i++)
        add_byte(i == 0, sec_q[i], 1'b0, (i == 0) ? pid : 13'($urandom), 1'b1);
    end else if (r < 94) begin
      extra = $urandom_range(1, 6);
      for (int i = 0; i < sec_q.size(); i++)
        add_byte(i == 0, sec_q[i], 1'b0, (i == 0) ? pid : 13'($urandom), 1'b1);
      for (int i = 1; i <= extra; i++)
        add_byte(1'b0, 8'($urandom), i == extra, 13'($urandom), 1'b1);
    end else begin
      last = sec_q.size() - 1;
      for (int i = 0; i <= last; i++)
        add_byte(i == 0, sec_q[i], i == last, (i == 0) ? pid : 13'($urandom), 1'b1);
      // stray bytes after the end are ignored
      repeat ($urandom_range(1, 3))
        add_byte(1'b0, 8'($urandom), 1'($urandom_range(0, 1)), 13'($urandom), 1'b0);
    end
  endtask

  task automatic fill_stimulus();
    int unsigned r;
    // Directed: stray bytes before any start
    add_byte(1'b0, 8'hff, 1'b1, 13'h1fff, 1'b0);
    add_byte(1'b0, 8'h00, 1'b0, 13'h0000, 1'b0);
    // One-byte section, then a three-byte one: both too short
    add_byte(1'b1, TID_PMT, 1'b1, 13'h0000, 1'b1);
    add_byte(1'b1, TID_PAT, 1'b0, 13'h1fff, 1'b1);
    add_byte(1'b0, 8'hb0, 1'b0, 13'h0000, 1'b1);
    add_byte(1'b0, 8'h0d, 1'b1, 13'h0000, 1'b1);
    // Syntax bit clear, then an unknown table id: ignored
    add_byte(1'b1, TID_PMT, 1'b0, 13'h0100, 1'b1);
    add_byte(1'b0, 8'h30, 1'b0, 13'h0000, 1'b1);
    add_byte(1'b0, 8'h05, 1'b0, 13'h0000, 1'b1);
    add_byte(1'b0, 8'h00, 1'b0, 13'h0000, 1'b1);
    add_byte(1'b0, 8'h01, 1'b1, 13'h0000, 1'b1);
    add_byte(1'b1, TID_OTHER, 1'b0, 13'h0001, 1'b1);
    add_byte(1'b0, 8'hf0, 1'b0, 13'h0000, 1'b1);
    add_byte(1'b0, 8'h11, 1'b0, 13'h0000, 1'b1);
    add_byte(1'b0, 8'h12, 1'b1, 13'h0000, 1'b1);
    // PMT header at the field extremes, dropped by the next start
    sec_q = {TID_PMT, 8'hb0, 8'h0d, 8'hff, 8'hff, 8'hc1, 8'h00, 8'h00,
             8'hff, 8'hff, 8'hf0, 8'h00};
    for (int i = 0; i < sec_q.size(); i++)
      add_byte(i == 0, sec_q[i], 1'b0, (i == 0) ? 13'h1fff : 13'h0000, 1'b1);

    // Random sections, mostly well formed
    while (gen_count < 500) begin
      r = $urandom_range(0, 99);
      if (r < 40) build_pat();
      else if (r < 80) build_pmt();
      else build_other();
      send_section();
    end

    // Ordinary section to close the run
    build_pmt();
    for (int i = 0; i < sec_q.size(); i++)
      add_byte(i == 0, sec_q[i], i == sec_q.size() - 1, 13'($urandom), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Input side: driver and monitor
  // ---------------------------------------------------------------------------

  int unsigned send_gap;
  int unsigned sent_total;
  byte_item_t  next_byte;

  // Present the next byte once the current transfer is done
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || in_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        next_byte = pending_bytes.pop_front();
        s_tdata <= {3'b000, next_byte.pid, next_byte.b};
        s_tuser <= next_byte.sos;
        s_tlast <= next_byte.eod;
        s_tvalid <= 1'b1;
        sent_total++;
        send_gap = pick_gap((sent_total % 256) < 48);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  byte_item_t taken_byte;
  result_t    predicted;

  // Predict on every accepted input transfer
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_tvalid && s_tready;
    if (rst_ni && s_tvalid && s_tready) begin
      in_count <= in_count + 1;
      taken_byte.sos = s_tuser;
      taken_byte.b = s_tdata[7:0];
      taken_byte.eod = s_tlast;
      taken_byte.pid = s_tdata[20:8];
      if (parse_section_byte(taken_byte, predicted))
        expected_entries.insert(expected_entries.size(), predicted);
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: receiver and checker
  // ---------------------------------------------------------------------------

  // Long hold on the result channel while the sender keeps going
  always @(posedge clk_i) begin
    if (!hold_done && in_count >= HOLD_AT) begin
      hold_on <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_on) begin
      if (hold_left == 0) hold_on <= 1'b0;
      else hold_left <= hold_left - 1;
    end
  end

  int unsigned recv_stall;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_on) begin
      m_tready <= 1'b0;
    end else if (recv_stall != 0) begin
      recv_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      recv_stall = pick_gap((cycle_count % 1024) < 160);
    end
  end

  result_t got, want;

  // Compare each output transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      got.kind = entry_kind_e'(m_tuser);
      got.pid = m_tdata[12:0];
      got.prog = m_tdata[28:13];
      got.status = end_status_e'(m_tdata[30:29]);
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual kind %0h pid %0h prog %0h st %0h",
                 $time, got.kind, got.pid, got.prog, got.status);
        mismatches++;
      end else begin
        want = expected_entries.pop_front();
        if (got.kind != want.kind) begin
          $display("%0t: kind mismatch: expected %0h actual %0h", $time, want.kind, got.kind);
          mismatches++;
        end
        if (got.pid != want.pid) begin
          $display("%0t: pid mismatch: expected %0h actual %0h", $time, want.pid, got.pid);
          mismatches++;
        end
        if (got.prog != want.prog) begin
          $display("%0t: program mismatch: expected %0h actual %0h", $time, want.prog, got.prog);
          mismatches++;
        end
        if (got.status != want.status) begin
          $display("%0t: status mismatch: expected %0h actual %0h",
                   $time, want.status, got.status);
          mismatches++;
        end
      end
      if (m_tdata[31] !== 1'b0) begin
        $display("%0t: pad bit mismatch: expected 0 actual %b", $time, m_tdata[31]);
        mismatches++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_entries.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_section = 1'b0;
    sec = '0;
    gen_count = 0;
    mismatches = 0;
    cycle_count = 0;
    in_count = 0;
    in_taken = 1'b0;
    hold_on = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    send_gap = 0;
    sent_total = 0;
    recv_stall = 0;
    fill_stimulus();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last input transfer, then for the last result
    @(posedge clk_i);
    while (pending_bytes.size() != 0 || s_tvalid) @(posedge clk_i);
    while (expected_entries.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
